### rtl/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
// No dependencies.
`default_nettype none

package cau_pkg;

    localparam int DW   = 16;          // operand and result width
    localparam int FW   = 8;           // fraction bits
    localparam int P_W  = 2 * DW;      // product width
    localparam int S_W  = 2 * DW + 1;  // sum of two products
    localparam int N_W  = 2 * DW;      // magnitude of a sum, norm
    localparam int Q_W  = DW + 1;      // quotient bits kept
    localparam int SQ_W = DW;          // root bits
    localparam int R_W  = N_W + Q_W;   // divider remainder

    localparam logic [2:0] FUNC_ADD = 3'd0;
    localparam logic [2:0] FUNC_SUB = 3'd1;
    localparam logic [2:0] FUNC_MUL = 3'd2;
    localparam logic [2:0] FUNC_DIV = 3'd3;
    localparam logic [2:0] FUNC_MAG = 3'd4;

    typedef struct packed {
        logic [2:0]           func;
        logic signed [DW-1:0] a_re;
        logic signed [DW-1:0] a_im;
        logic signed [DW-1:0] b_re;
        logic signed [DW-1:0] b_im;
    } req_t;

    typedef struct packed {
        logic signed [DW-1:0] res_re;
        logic signed [DW-1:0] res_im;
        logic                 overflow;
        logic                 div_by_zero;
    } rsp_t;

    // item state while it walks the divide / square root stages
    typedef struct packed {
        logic [2:0]     func;
        logic           dz;
        logic           re_neg;
        logic           im_neg;
        logic           re_huge;
        logic           im_huge;
        logic [R_W-1:0] re_rem;
        logic [R_W-1:0] im_rem;
        logic [Q_W-1:0] re_q;
        logic [Q_W-1:0] im_q;
        logic [N_W-1:0] den;
    } iter_t;

endpackage

`default_nettype wire

### rtl/cau_front.sv
// Front stages: request register, products, sums, sign/magnitude setup.
// Depends on cau_pkg.
`default_nettype none

module cau_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_vld,
    input  wire cau_pkg::req_t in_req,
    output logic               out_vld,
    output cau_pkg::iter_t     out_item
);
    import cau_pkg::*;

    // stage A
    logic a_vld_reg;
    req_t a_reg;

    // stage B
    logic                  b_vld_reg;
    req_t                  b_reg;
    logic signed [P_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_nr_reg, p_ni_reg;
    logic signed [P_W-1:0] p_rr_next, p_ii_next;
    logic signed [DW-1:0]  y0, y1;

    // stage C
    logic                  c_vld_reg;
    logic [2:0]            c_func_reg;
    logic signed [S_W-1:0] c_re_reg, c_im_reg, c_re_next, c_im_next;
    logic [N_W-1:0]        c_norm_reg, c_norm_next;

    // stage D
    logic                  d_vld_reg;
    iter_t                 d_reg, d_next;
    logic signed [S_W-1:0] abs_re, abs_im;
    logic [N_W-1:0]        mag_re, mag_im;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else if (en) begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    // magnitude squares a through the first two multipliers
    assign y0        = (a_reg.func == FUNC_MAG) ? a_reg.a_re : a_reg.b_re;
    assign y1        = (a_reg.func == FUNC_MAG) ? a_reg.a_im : a_reg.b_im;
    assign p_rr_next = a_reg.a_re * y0;
    assign p_ii_next = a_reg.a_im * y1;

    always_comb begin
        c_re_next   = '0;
        c_im_next   = '0;
        c_norm_next = {1'b0, p_nr_reg[N_W-2:0]} + {1'b0, p_ni_reg[N_W-2:0]};
        unique case (b_reg.func)
            FUNC_ADD:
            begin
                c_re_next = S_W'(b_reg.a_re) + S_W'(b_reg.b_re);
                c_im_next = S_W'(b_reg.a_im) + S_W'(b_reg.b_im);
            end
            FUNC_SUB:
            begin
                c_re_next = S_W'(b_reg.a_re) - S_W'(b_reg.b_re);
                c_im_next = S_W'(b_reg.a_im) - S_W'(b_reg.b_im);
            end
            FUNC_MUL:
            begin
                c_re_next = S_W'(p_rr_reg) - S_W'(p_ii_reg);
                c_im_next = S_W'(p_ri_reg) + S_W'(p_ir_reg);
            end
            FUNC_DIV:
            begin
                c_re_next = S_W'(p_rr_reg) + S_W'(p_ii_reg);
                c_im_next = S_W'(p_ir_reg) - S_W'(p_ri_reg);
            end
            FUNC_MAG:
            begin
                c_re_next = S_W'(p_rr_reg) + S_W'(p_ii_reg);
            end
            default:
            begin
                c_re_next = '0;
            end
        endcase
    end

    assign abs_re = c_re_reg[S_W-1] ? -c_re_reg : c_re_reg;
    assign abs_im = c_im_reg[S_W-1] ? -c_im_reg : c_im_reg;
    assign mag_re = abs_re[N_W-1:0];
    assign mag_im = abs_im[N_W-1:0];

    always_comb begin
        d_next        = '0;
        d_next.func   = c_func_reg;
        d_next.den    = c_norm_reg;
        d_next.re_neg = c_re_reg[S_W-1];
        d_next.im_neg = c_im_reg[S_W-1];
        unique case (c_func_reg)
            FUNC_ADD, FUNC_SUB:
            begin
                d_next.re_q = mag_re[Q_W-1:0];
                d_next.im_q = mag_im[Q_W-1:0];
            end
            FUNC_MUL:
            begin
                d_next.re_q    = mag_re[FW +: Q_W];
                d_next.im_q    = mag_im[FW +: Q_W];
                d_next.re_huge = |mag_re[N_W-1:FW+Q_W];
                d_next.im_huge = |mag_im[N_W-1:FW+Q_W];
            end
            FUNC_DIV:
            begin
                if (c_norm_reg == '0) begin
                    d_next.dz     = 1'b1;
                    d_next.re_neg = 1'b0;
                    d_next.im_neg = 1'b0;
                end
                else begin
                    d_next.re_rem  = {{(R_W-N_W-FW){1'b0}}, mag_re, {FW{1'b0}}};
                    d_next.im_rem  = {{(R_W-N_W-FW){1'b0}}, mag_im, {FW{1'b0}}};
                    d_next.re_huge = {{(Q_W-FW){1'b0}}, mag_re}
                                     >= {c_norm_reg, {(Q_W-FW){1'b0}}};
                    d_next.im_huge = {{(Q_W-FW){1'b0}}, mag_im}
                                     >= {c_norm_reg, {(Q_W-FW){1'b0}}};
                end
            end
            FUNC_MAG:
            begin
                d_next.re_neg = 1'b0;
                d_next.im_neg = 1'b0;
                d_next.re_rem = {{(R_W-N_W){1'b0}}, mag_re};
            end
            default:
            begin
                d_next.re_neg = 1'b0;
                d_next.im_neg = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (en) begin
            a_reg      <= in_req;
            b_reg      <= a_reg;
            p_rr_reg   <= p_rr_next;
            p_ii_reg   <= p_ii_next;
            p_ri_reg   <= a_reg.a_re * a_reg.b_im;
            p_ir_reg   <= a_reg.a_im * a_reg.b_re;
            p_nr_reg   <= a_reg.b_re * a_reg.b_re;
            p_ni_reg   <= a_reg.b_im * a_reg.b_im;
            c_func_reg <= b_reg.func;
            c_re_reg   <= c_re_next;
            c_im_reg   <= c_im_next;
            c_norm_reg <= c_norm_next;
            d_reg      <= d_next;
        end
    end

    assign out_vld  = d_vld_reg;
    assign out_item = d_reg;

endmodule

`default_nettype wire

### rtl/cau_iter.sv
// Pipelined restoring divider (both parts) and square root, one bit per stage.
// Depends on cau_pkg.
`default_nettype none

module cau_iter (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_vld,
    input  wire cau_pkg::iter_t in_item,
    output logic                out_vld,
    output cau_pkg::iter_t      out_item
);
    import cau_pkg::*;

    logic  vld_reg  [Q_W];
    iter_t pipe_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        iter_t          cur, nxt;
        logic           cur_vld;
        logic [R_W-1:0] dtrial, strial;
        logic [Q_W-1:0] sq_bit;
        logic           sq_en;

        if (k == 0) begin : g_first
            assign cur     = in_item;
            assign cur_vld = in_vld;
        end
        else begin : g_next
            assign cur     = pipe_reg[k-1];
            assign cur_vld = vld_reg[k-1];
        end

        assign dtrial = {{(R_W-N_W){1'b0}}, cur.den} << (Q_W-1-k);

        if (k < SQ_W) begin : g_sq
            assign strial = ({{(R_W-Q_W){1'b0}}, cur.re_q} << (SQ_W-k))
                            | ({{(R_W-1){1'b0}}, 1'b1} << (2*(SQ_W-1-k)));
            assign sq_bit = {{(Q_W-1){1'b0}}, 1'b1} << (SQ_W-1-k);
            assign sq_en  = 1'b1;
        end
        else begin : g_nosq
            assign strial = '0;
            assign sq_bit = '0;
            assign sq_en  = 1'b0;
        end

        always_comb begin
            nxt = cur;
            if (cur.func == FUNC_DIV && !cur.dz) begin
                if (cur.re_rem >= dtrial) begin
                    nxt.re_rem          = cur.re_rem - dtrial;
                    nxt.re_q[Q_W-1-k]   = 1'b1;
                end
                if (cur.im_rem >= dtrial) begin
                    nxt.im_rem          = cur.im_rem - dtrial;
                    nxt.im_q[Q_W-1-k]   = 1'b1;
                end
            end
            else if (cur.func == FUNC_MAG && sq_en && cur.re_rem >= strial) begin
                nxt.re_rem = cur.re_rem - strial;
                nxt.re_q   = cur.re_q | sq_bit;
            end
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                vld_reg[k] <= 1'b0;
            end
            else if (en) begin
                vld_reg[k] <= cur_vld;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                pipe_reg[k] <= nxt;
            end
        end
    end

    assign out_vld  = vld_reg[Q_W-1];
    assign out_item = pipe_reg[Q_W-1];

endmodule

`default_nettype wire

### rtl/cau_back.sv
// Output stage: sign, saturation, flags and the result register.
// Depends on cau_pkg.
`default_nettype none

module cau_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_vld,
    input  wire cau_pkg::iter_t in_item,
    output logic                out_vld,
    output cau_pkg::rsp_t       out_rsp
);
    import cau_pkg::*;

    localparam logic [DW-1:0]  MAX_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0]  MAX_NEG = {1'b1, {(DW-1){1'b0}}};
    localparam logic [Q_W-1:0] LIM_POS = {2'b00, {(DW-1){1'b1}}};
    localparam logic [Q_W-1:0] LIM_NEG = {2'b01, {(DW-1){1'b0}}};

    logic          vld_reg;
    rsp_t          rsp_reg, rsp_next;
    logic [DW:0]   sat_re, sat_im;

    // returns {overflow, value}
    function automatic logic [DW:0] sat(input logic neg, input logic huge,
                                        input logic [Q_W-1:0] mag);
        logic [Q_W-1:0] negv;
        negv = -mag;
        if (huge) begin
            sat = {1'b1, neg ? MAX_NEG : MAX_POS};
        end
        else if (neg && mag != '0) begin
            if (mag > LIM_NEG) begin
                sat = {1'b1, MAX_NEG};
            end
            else begin
                sat = {1'b0, negv[DW-1:0]};
            end
        end
        else if (mag > LIM_POS) begin
            sat = {1'b1, MAX_POS};
        end
        else begin
            sat = {1'b0, mag[DW-1:0]};
        end
    endfunction

    assign sat_re = sat(in_item.re_neg, in_item.re_huge, in_item.re_q);
    assign sat_im = sat(in_item.im_neg, in_item.im_huge, in_item.im_q);

    always_comb begin
        rsp_next.res_re      = sat_re[DW-1:0];
        rsp_next.res_im      = sat_im[DW-1:0];
        rsp_next.overflow    = sat_re[DW] | sat_im[DW];
        rsp_next.div_by_zero = in_item.dz;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= 1'b0;
        end
        else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            rsp_reg <= rsp_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_rsp = rsp_reg;

endmodule

`default_nettype wire

### rtl/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply, divide, magnitude, Q8.8.
// One request per cycle sustained while res_stall does not freeze the pipeline;
// the divider / square root has 17 stages with one quotient bit per stage.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits; data registers are not reset. Requests are
// stalled during reset and in the first cycle after it.
// Depends on cau_pkg, cau_front, cau_iter, cau_back.
`default_nettype none

module complex_arithmetic_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire cau_pkg::req_t req_data,
    output logic               res_valid,
    input  wire logic          res_stall,
    output cau_pkg::rsp_t      res_data
);
    import cau_pkg::*;

    logic  en;
    logic  run_reg;
    logic  f_vld, i_vld;
    iter_t f_item, i_item;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_reg <= 1'b0;
        end
        else begin
            run_reg <= 1'b1;
        end
    end

    assign en        = !res_valid || !res_stall;
    assign req_stall = !en || !run_reg;

    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (req_valid && run_reg),
        .in_req   (req_data),
        .out_vld  (f_vld),
        .out_item (f_item)
    );

    cau_iter u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (f_vld),
        .in_item  (f_item),
        .out_vld  (i_vld),
        .out_item (i_item)
    );

    cau_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (i_vld),
        .in_item  (i_item),
        .out_vld  (res_valid),
        .out_rsp  (res_data)
    );

endmodule

`default_nettype wire

### tb/complex_arithmetic_unit_test.sv
// Self-checking testbench for the complex arithmetic unit.
// Predicts each result from the request fields and compares them in order.
// Depends on cau_pkg and complex_arithmetic_unit.
`default_nettype none

module complex_arithmetic_unit_test;
    import cau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY   = 21;
    localparam int IDLE_MAX  = 20000;
    localparam int HOLD_LEN  = 120;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_stall;
    req_t  req_data = '0;
    logic  res_valid;
    logic  res_stall = 1'b0;
    rsp_t  res_data;

    req_t  pending_reqs[$];
    rsp_t  expected_rsps[$];
    int    errors = 0;
    int    idle_cycles = 0;
    int    req_count = 0;
    bit    quiet = 1'b0;
    bit    hold_done = 1'b0;
    int    hold_left = 0;

    complex_arithmetic_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
        .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic signed [DW-1:0] clamp(input logic signed [63:0] v,
                                                   inout logic ovf);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (DW - 1)) - 1;
        lo = -(64'sd1 <<< (DW - 1));
        if (v > hi)
        begin
            ovf = 1'b1;
            return hi[DW-1:0];
        end
        if (v < lo)
        begin
            ovf = 1'b1;
            return lo[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

    // signed numerator scaled by 2^FW, divided by positive norm, toward zero; 2^40 if out of range
    function automatic logic signed [63:0] scaled_quot(input logic signed [63:0] n,
                                                       input logic signed [63:0] d);
        logic [63:0] mag;
        logic [63:0] q;
        mag = (n < 0) ? 64'(-n) : 64'(n);
        q = mag / 64'(d);
        if (q > 64'(((64'd1 << (DW - 1)) >> FW)))
            q = 64'd1 << 40;
        else
            q = (mag << FW) / 64'(d);
        return (n < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r;
        r = 0;
        for (int b = 31; b >= 0; b--)
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= n)
                r |= 64'd1 << b;
        return r;
    endfunction

    function automatic rsp_t compute_complex(input req_t rq);
        rsp_t r;
        logic signed [63:0] ar, ai, br, bi, re, im, norm;
        logic ovf;
        ar = rq.a_re; ai = rq.a_im; br = rq.b_re; bi = rq.b_im;
        re = 0; im = 0; ovf = 1'b0;
        r = '0;
        case (rq.func)
            FUNC_ADD:
            begin
                re = ar + br; im = ai + bi;
            end
            FUNC_SUB:
            begin
                re = ar - br; im = ai - bi;
            end
            FUNC_MUL:
            begin
                re = ar * br - ai * bi;
                im = ar * bi + ai * br;
                re = (re < 0) ? -((-re) >>> FW) : (re >>> FW);
                im = (im < 0) ? -((-im) >>> FW) : (im >>> FW);
            end
            FUNC_DIV:
            begin
                norm = br * br + bi * bi;
                if (norm == 0)
                    r.div_by_zero = 1'b1;
                else
                begin
                    re = scaled_quot(ar * br + ai * bi, norm);
                    im = scaled_quot(ai * br - ar * bi, norm);
                end
            end
            FUNC_MAG: re = $signed(int_sqrt(64'(ar * ar + ai * ai)));
            default: ;
        endcase
        r.res_re = clamp(re, ovf);
        r.res_im = clamp(im, ovf);
        r.overflow = ovf;
        return r;
    endfunction

    function automatic logic signed [DW-1:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(signed'($urandom_range(0, 1024)) - 512);
            3: return '0;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_req(input logic [2:0] f, input logic signed [DW-1:0] a0,
                             input logic signed [DW-1:0] a1,
                             input logic signed [DW-1:0] b0,
                             input logic signed [DW-1:0] b1);
        req_t rq;
        rq.func = f; rq.a_re = a0; rq.a_im = a1; rq.b_re = b0; rq.b_im = b1;
        pending_reqs.push_back(rq);
    endtask

    // driver
    always @(posedge clk)
    begin
        bit fire;
        fire = req_valid && !req_stall;
        if (fire)
            expected_rsps.push_back(compute_complex(req_data));
        if (!req_valid || fire)
        begin
            if (pending_reqs.size() > 0 && (quiet || $urandom_range(0, 99) >= 33))
            begin
                req_valid <= 1'b1;
                req_data <= pending_reqs.pop_front();
                req_count++;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rsp_t e;
        if (res_valid && !res_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                e = expected_rsps.pop_front();
                if (res_data.res_re !== e.res_re)
                begin
                    $error("res_re exp %0d got %0d", e.res_re, res_data.res_re);
                    errors++;
                end
                if (res_data.res_im !== e.res_im)
                begin
                    $error("res_im exp %0d got %0d", e.res_im, res_data.res_im);
                    errors++;
                end
                if (res_data.overflow !== e.overflow)
                begin
                    $error("overflow exp %0b got %0b", e.overflow, res_data.overflow);
                    errors++;
                end
                if (res_data.div_by_zero !== e.div_by_zero)
                begin
                    $error("div_by_zero exp %0b got %0b", e.div_by_zero,
                           res_data.div_by_zero);
                    errors++;
                end
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            res_stall <= 1'b1;
        end
        else if (!hold_done && req_count > 400)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            res_stall <= 1'b1;
        end
        else
            res_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 33);
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (res_valid && !res_stall))
            idle_cycles = 0;
        else if (rst_n && (pending_reqs.size() > 0 || expected_rsps.size() > 0))
            idle_cycles++;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        logic [2:0] f;
        int drain;
        queue_req(FUNC_ADD, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
        queue_req(FUNC_ADD, 16'sh0100, -16'sh0080, 16'sh0200, 16'sh0040);
        queue_req(FUNC_SUB, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        queue_req(FUNC_SUB, 16'sh0300, 16'sh0100, 16'sh0100, 16'sh0300);
        queue_req(FUNC_MUL, 16'sh0200, 16'sh0100, 16'sh0300, -16'sh0100);
        queue_req(FUNC_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        queue_req(FUNC_MUL, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        queue_req(FUNC_MUL, -16'sh0001, 16'sh0001, 16'sh0001, 16'sh0001);
        queue_req(FUNC_DIV, 16'sh0400, 16'sh0200, 16'sh0100, 16'sh0100);
        queue_req(FUNC_DIV, 16'sh0100, 16'sh0100, 16'sh0000, 16'sh0000);
        queue_req(FUNC_DIV, 16'sh7FFF, 16'sh8000, 16'sh0001, 16'sh0000);
        queue_req(FUNC_DIV, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        queue_req(FUNC_DIV, -16'sh0100, 16'sh0003, 16'sh0300, -16'sh0700);
        queue_req(FUNC_MAG, 16'sh0300, 16'sh0400, 16'sh1234, 16'sh5678);
        queue_req(FUNC_MAG, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000);
        queue_req(FUNC_MAG, 16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000);
        queue_req(FUNC_MAG, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
        queue_req(3'd5, 16'sh1111, 16'sh2222, 16'sh3333, 16'sh4444);
        queue_req(3'd6, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF);
        queue_req(3'd7, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
        for (int i = 0; i < 1030; i++)
        begin
            f = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
            if (f == FUNC_DIV && $urandom_range(0, 9) == 0)
                queue_req(f, pick_operand(), pick_operand(), '0, '0);
            else
                queue_req(f, pick_operand(), pick_operand(), pick_operand(),
                          pick_operand());
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        wait (req_count > 700);
        quiet = 1'b1;
        wait (req_count > 850);
        quiet = 1'b0;
        wait (pending_reqs.size() == 0 && !req_valid);
        wait (expected_rsps.size() == 0);
        drain = 0;
        while (drain < 4 * LATENCY)
        begin
            @(posedge clk);
            drain++;
        end
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_iter.sv
rtl/cau_back.sv
rtl/complex_arithmetic_unit.sv
tb/complex_arithmetic_unit_test.sv
